// ----- src/ccpt_pkg.sv -----
// Shared constants, types and codes for the caller/callee profile table.
package ccpt_pkg;

  localparam int NumFuncs     = 1024;
  localparam int OverflowSlot = 7;
  localparam int SlotsPerRow  = OverflowSlot + 1;
  localparam int RowW         = $clog2(NumFuncs);
  localparam int SlotW        = $clog2(SlotsPerRow);
  localparam int DataAw       = RowW + SlotW;
  localparam int DataDepth    = 1 << DataAw;

  localparam int ReqW     = 2;
  localparam int IdxW     = 10;
  localparam int TsW      = 64;
  localparam int CntW     = 32;
  localparam int RdSlotW  = 3;
  localparam int StatusW  = 3;
  localparam int ApbAw    = 2;
  localparam int ApbDw    = 32;

  localparam logic [ApbAw-1:0] AddrEnable = '0;

  typedef enum logic [ReqW-1:0] {
    REQ_ENTER = 2'd0,
    REQ_EXIT  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_MATCH    = 3'd0,
    ST_CLAIM    = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_DONE     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OK_EVENT,
    OK_READ,
    OK_IGNORED,
    OK_CLEAR
  } outk_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD_ROW,
    S_SEARCH,
    S_RD_SLOT,
    S_CALC,
    S_WRITE,
    S_CLEAR,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [SlotsPerRow-1:0]           touched;
    logic [SlotsPerRow-1:0][IdxW-1:0] parent;
  } row_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic [TsW-1:0]  pending;
    logic [TsW-1:0]  total;
  } slot_data_t;

  typedef struct packed {
    logic  accept;
    logic  sweep;
    logic  rd_row;
    logic  search;
    logic  rd_slot;
    logic  calc;
    logic  write;
    logic  load_out;
    outk_e kind;
  } ccpt_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_read;
    logic ev_ok;
    logic exit_claim;
    logic sweep_last;
    logic out_free;
  } ccpt_stat_t;

endpackage

// ----- src/ccpt_ctrl.sv -----
// Sequencing state machine for the caller/callee profile table.
module ccpt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ccpt_pkg::ccpt_stat_t stat_i,
  output ccpt_pkg::ccpt_cmd_t  cmd_o
);
  import ccpt_pkg::*;

  state_e state_q, state_d;
  outk_e  kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      kind_q  <= OK_CLEAR;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    in_stall_o = 1'b1;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_RD_ROW;
        end
      end
      S_RD_ROW: begin
        cmd_o.rd_row = 1'b1;
        if (stat_i.is_clear) begin
          state_d = S_CLEAR;
        end else if (!stat_i.is_read && !stat_i.ev_ok) begin
          kind_d  = OK_IGNORED;
          state_d = S_FINISH;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (stat_i.exit_claim) begin
          kind_d  = OK_IGNORED;
          state_d = S_FINISH;
        end else begin
          state_d = S_RD_SLOT;
        end
      end
      S_RD_SLOT: begin
        cmd_o.rd_slot = 1'b1;
        state_d       = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        if (stat_i.is_read) begin
          kind_d  = OK_READ;
          state_d = S_FINISH;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        kind_d      = OK_EVENT;
        state_d     = S_FINISH;
      end
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          kind_d  = OK_CLEAR;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

endmodule

// ----- src/ccpt_dp.sv -----
// Datapath of the caller/callee profile table: tables, search, update and result beat.
module ccpt_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ccpt_pkg::ccpt_cmd_t                 cmd_i,
  output ccpt_pkg::ccpt_stat_t                stat_o,
  input  logic [ccpt_pkg::ReqW-1:0]           req_type_i,
  input  logic [ccpt_pkg::IdxW-1:0]           func_index_i,
  input  logic [ccpt_pkg::IdxW-1:0]           caller_index_i,
  input  logic [ccpt_pkg::TsW-1:0]            timestamp_i,
  input  logic [ccpt_pkg::RdSlotW-1:0]        read_slot_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ccpt_pkg::StatusW-1:0]        status_o,
  output logic [ccpt_pkg::RdSlotW-1:0]        slot_used_o,
  output logic [ccpt_pkg::IdxW-1:0]           slot_caller_o,
  output logic [ccpt_pkg::CntW-1:0]           call_count_o,
  output logic [ccpt_pkg::TsW-1:0]            pending_sum_o,
  output logic [ccpt_pkg::TsW-1:0]            run_time_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ccpt_pkg::ApbAw-1:0]          paddr,
  input  logic [ccpt_pkg::ApbDw-1:0]          pwdata,
  output logic [ccpt_pkg::ApbDw-1:0]          prdata,
  output logic                                pready
);
  import ccpt_pkg::*;

  logic enable_q;

  req_e                 req_q;
  logic [IdxW-1:0]      func_q;
  logic [IdxW-1:0]      caller_q;
  logic [TsW-1:0]       ts_q;
  logic [RdSlotW-1:0]   rslot_q;

  row_t                 prow_mem [NumFuncs];
  row_t                 prow_rd_q;
  row_t                 prow_new;
  slot_data_t           dmem [DataDepth];
  slot_data_t           dmem_rd_q;

  logic [RowW-1:0]      row_addr;
  logic [RowW-1:0]      sweep_cnt_q;
  logic                 sweep_last;
  logic [DataAw-1:0]    daddr;
  logic                 in_range;
  logic                 read_ok;

  logic                 found;
  logic [SlotW-1:0]     srch_slot;
  status_e              srch_st;
  logic [SlotW-1:0]     slot_q;
  status_e              st_q;

  slot_data_t           cur;
  slot_data_t           cur_q;
  logic [CntW-1:0]      cnt_inc_q;
  logic [TsW-1:0]       pend_add_q;
  logic [TsW-1:0]       diff_q;
  logic [TsW-1:0]       rdiff_q;
  logic                 ge_q;
  logic [TsW:0]         diff_w;
  slot_data_t           upd_d;
  slot_data_t           upd_q;
  logic [IdxW-1:0]      ev_parent;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [RdSlotW-1:0]   out_slot_q;
  logic [IdxW-1:0]      out_caller_q;
  slot_data_t           out_data_q;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == AddrEnable) ? {{(ApbDw-1){1'b0}}, enable_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == AddrEnable)) begin
      enable_q <= pwdata[0];
    end
  end

  // capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q    <= req_e'(req_type_i);
      func_q   <= func_index_i;
      caller_q <= caller_index_i;
      ts_q     <= timestamp_i;
      rslot_q  <= read_slot_i;
    end
  end

  assign row_addr = RowW'(func_q);
  assign in_range = int'(func_q) < NumFuncs;
  assign read_ok  = in_range && (int'(rslot_q) <= OverflowSlot);
  assign daddr    = {row_addr, slot_q};

  // row sweep after reset and on clear
  assign sweep_last = (sweep_cnt_q == RowW'(NumFuncs - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_cnt_q <= sweep_last ? '0 : sweep_cnt_q + 1'b1;
    end
  end

  // parent row memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      prow_mem[sweep_cnt_q] <= '0;
    end else if (cmd_i.write) begin
      prow_mem[row_addr] <= prow_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_row) begin
      prow_rd_q <= prow_mem[row_addr];
    end
  end

  // slot search
  always_comb begin
    found     = 1'b0;
    srch_slot = SlotW'(OverflowSlot);
    srch_st   = ST_OVERFLOW;
    if (caller_q != '0) begin
      for (int i = 0; i < OverflowSlot; i++) begin
        if (!found) begin
          if (prow_rd_q.parent[i] == '0) begin
            found     = 1'b1;
            srch_slot = SlotW'(i);
            srch_st   = ST_CLAIM;
          end else if (prow_rd_q.parent[i] == caller_q) begin
            found     = 1'b1;
            srch_slot = SlotW'(i);
            srch_st   = ST_MATCH;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      slot_q <= (req_q == REQ_READ) ? SlotW'(rslot_q) : srch_slot;
      st_q   <= srch_st;
    end
  end

  // slot data memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      dmem[daddr] <= upd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_slot) begin
      dmem_rd_q <= dmem[daddr];
    end
  end

  assign cur    = prow_rd_q.touched[slot_q] ? dmem_rd_q : '0;
  assign diff_w = {1'b0, ts_q} - {1'b0, cur.pending};

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      cur_q      <= cur;
      cnt_inc_q  <= cur.count + 1'b1;
      pend_add_q <= cur.pending + ts_q;
      diff_q     <= diff_w[TsW-1:0];
      rdiff_q    <= cur.pending - ts_q;
      ge_q       <= !diff_w[TsW];
    end
  end

  always_comb begin
    upd_d = cur_q;
    if (req_q == REQ_ENTER) begin
      upd_d.count   = cnt_inc_q;
      upd_d.pending = pend_add_q;
    end else if (ge_q) begin
      upd_d.total   = cur_q.total + diff_q;
      upd_d.pending = '0;
    end else begin
      upd_d.pending = rdiff_q;
    end
  end

  always_comb begin
    prow_new                  = prow_rd_q;
    prow_new.touched[slot_q]  = 1'b1;
    if (st_q == ST_CLAIM) begin
      prow_new.parent[slot_q] = caller_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      upd_q <= upd_d;
    end
  end

  assign ev_parent = (st_q == ST_CLAIM) ? caller_q : prow_rd_q.parent[slot_q];

  // result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      case (cmd_i.kind)
        OK_EVENT: begin
          out_status_q <= st_q;
          out_slot_q   <= RdSlotW'(slot_q);
          out_caller_q <= ev_parent;
          out_data_q   <= upd_q;
        end
        OK_READ: begin
          out_status_q <= ST_DONE;
          out_slot_q   <= rslot_q;
          out_caller_q <= read_ok ? prow_rd_q.parent[slot_q] : '0;
          out_data_q   <= read_ok ? cur_q : '0;
        end
        OK_IGNORED: begin
          out_status_q <= ST_IGNORED;
          out_slot_q   <= '0;
          out_caller_q <= '0;
          out_data_q   <= '0;
        end
        default: begin
          out_status_q <= ST_DONE;
          out_slot_q   <= '0;
          out_caller_q <= '0;
          out_data_q   <= '0;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_used_o   = out_slot_q;
  assign slot_caller_o = out_caller_q;
  assign call_count_o  = out_data_q.count;
  assign pending_sum_o = out_data_q.pending;
  assign run_time_o    = out_data_q.total;

  assign stat_o.is_clear   = (req_q == REQ_CLEAR);
  assign stat_o.is_read    = (req_q == REQ_READ);
  assign stat_o.ev_ok      = enable_q && in_range;
  assign stat_o.exit_claim = (req_q == REQ_EXIT) && (srch_st == ST_CLAIM);
  assign stat_o.sweep_last = sweep_last;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

// ----- src/caller_callee_profile_table.sv -----
// Top level of the caller/callee profile table.
//
//   channel  direction  handshake              beat
//   in       input      in_valid_i/in_stall_o  req_type, func_index, caller_index,
//                                              timestamp, read_slot
//   out      output     out_valid_o/out_stall_i status, slot_used, slot_caller,
//                                              call_count, pending_sum, run_time
//   cfg      input      psel/penable/pready    enable at address 0
//
// An enter or exit beat runs the row read, slot search, slot read, calculation and write
// (read-modify-write of both tables) before its result is loaded; a read skips the write,
// a disabled event ends after the row read, an exit on an empty slot after the search.
// The next beat is taken once the result is loaded. A clear request clears one table row
// per cycle. After reset the same row sweep covers all NumFuncs rows with in_stall_o high.
// A finished result waits in the output register while out_stall_i is high.
module caller_callee_profile_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ccpt_pkg::ReqW-1:0]     req_type_i,
  input  logic [ccpt_pkg::IdxW-1:0]     func_index_i,
  input  logic [ccpt_pkg::IdxW-1:0]     caller_index_i,
  input  logic [ccpt_pkg::TsW-1:0]      timestamp_i,
  input  logic [ccpt_pkg::RdSlotW-1:0]  read_slot_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ccpt_pkg::StatusW-1:0]  status_o,
  output logic [ccpt_pkg::RdSlotW-1:0]  slot_used_o,
  output logic [ccpt_pkg::IdxW-1:0]     slot_caller_o,
  output logic [ccpt_pkg::CntW-1:0]     call_count_o,
  output logic [ccpt_pkg::TsW-1:0]      pending_sum_o,
  output logic [ccpt_pkg::TsW-1:0]      run_time_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ccpt_pkg::ApbAw-1:0]    paddr,
  input  logic [ccpt_pkg::ApbDw-1:0]    pwdata,
  output logic [ccpt_pkg::ApbDw-1:0]    prdata,
  output logic                          pready
);
  import ccpt_pkg::*;

  ccpt_cmd_t  cmd;
  ccpt_stat_t stat;

  ccpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ccpt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_type_i     (req_type_i),
    .func_index_i   (func_index_i),
    .caller_index_i (caller_index_i),
    .timestamp_i    (timestamp_i),
    .read_slot_i    (read_slot_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_used_o    (slot_used_o),
    .slot_caller_o  (slot_caller_o),
    .call_count_o   (call_count_o),
    .pending_sum_o  (pending_sum_o),
    .run_time_o     (run_time_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

endmodule

// ----- src/ccpt_checker.sv -----
// Port-level checks for the caller/callee profile table, bound to the top level.
module ccpt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [ccpt_pkg::StatusW-1:0]  status_o,
  input logic [ccpt_pkg::RdSlotW-1:0]  slot_used_o,
  input logic [ccpt_pkg::IdxW-1:0]     slot_caller_o,
  input logic [ccpt_pkg::CntW-1:0]     call_count_o,
  input logic [ccpt_pkg::TsW-1:0]      pending_sum_o,
  input logic [ccpt_pkg::TsW-1:0]      run_time_o
);
  import ccpt_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input beat taken while previous request still in work");

  a_ignored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_IGNORED) |->
      slot_used_o == '0 && slot_caller_o == '0 && call_count_o == '0 &&
      pending_sum_o == '0 && run_time_o == '0)
    else $error("ignored event carries slot data");

  a_claim_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_CLAIM) |->
      call_count_o == 1 && slot_caller_o != '0 && run_time_o == '0)
    else $error("claimed slot not fresh");

  a_overflow_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OVERFLOW) |->
      slot_used_o == RdSlotW'(OverflowSlot) && slot_caller_o == '0)
    else $error("overflow status on wrong slot");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

endmodule

bind caller_callee_profile_table ccpt_checker u_ccpt_checker (.*);
